>>> hw/rtl/mrf_pkg.sv
package mrf_pkg;

  // Depth of the job queue between the command front end and the byte sequencer.
  localparam int unsigned MRF_FIFO_DEPTH = 2;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef enum logic [1:0] {
    CMD_READ         = 2'd0,
    CMD_WRITE_SINGLE = 2'd1,
    CMD_WRITE_MULTI  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_READ,
    JOB_WRITE_SINGLE,
    JOB_MULTI_HEAD,
    JOB_MULTI_DATA
  } job_e;

  typedef struct packed {
    job_e        op;
    logic        last;
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [7:0]  register_count;
    logic [15:0] data_word;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_CRC_LO,
    ST_CRC_HI
  } back_state_e;

  // Byte position inside one job; the longest job carries nine data bytes.
  typedef logic [3:0] idx_t;

endpackage

>>> hw/rtl/mrf_cmd_if.sv
interface mrf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  slave_address;
  logic [15:0] register_address;
  logic [7:0]  register_count;
  logic [15:0] data_word;
  logic        last_word;

  modport source (
    output valid, command, slave_address, register_address, register_count, data_word,
           last_word,
    input  ready
  );

  modport sink (
    input  valid, command, slave_address, register_address, register_count, data_word,
           last_word,
    output ready
  );
endinterface

>>> hw/rtl/mrf_byte_if.sv
interface mrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (
    output valid, frame_byte, end_of_frame,
    input  ready
  );

  modport sink (
    input  valid, frame_byte, end_of_frame,
    output ready
  );
endinterface

>>> hw/rtl/mrf_front.sv
module mrf_front import mrf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mrf_cmd_if.sink      cmd_i,
  input  fifo_status_t status_i,
  output logic         push_o,
  output job_t         job_o
);

  logic frame_open_q, frame_open_d;
  logic accept;

  assign cmd_i.ready = !status_i.full;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    push_o                 = 1'b0;
    frame_open_d           = frame_open_q;
    job_o.op               = JOB_READ;
    job_o.last             = cmd_i.last_word;
    job_o.slave_address    = cmd_i.slave_address;
    job_o.register_address = cmd_i.register_address;
    job_o.register_count   = cmd_i.register_count;
    job_o.data_word        = cmd_i.data_word;
    if (accept) begin
      case (cmd_e'(cmd_i.command))
        CMD_READ: begin
          push_o       = 1'b1;
          job_o.op     = JOB_READ;
          frame_open_d = 1'b0;
        end
        CMD_WRITE_SINGLE: begin
          push_o       = 1'b1;
          job_o.op     = JOB_WRITE_SINGLE;
          frame_open_d = 1'b0;
        end
        CMD_WRITE_MULTI: begin
          push_o       = 1'b1;
          job_o.op     = frame_open_q ? JOB_MULTI_DATA : JOB_MULTI_HEAD;
          frame_open_d = !cmd_i.last_word;
        end
        default: begin
          // The unused command code is consumed and dropped.
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

>>> hw/rtl/mrf_fifo.sv
module mrf_fifo import mrf_pkg::*; #(
  parameter int unsigned Depth = MRF_FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  job_t         job_i,
  input  logic         pop_i,
  output job_t         job_o,
  output fifo_status_t status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign job_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i)
    else $error("job queue read while empty");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("job queue count past its depth");
`endif

endmodule

>>> hw/rtl/mrf_back.sv
module mrf_back import mrf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fifo_status_t status_i,
  input  job_t         job_i,
  output logic         pop_o,
  mrf_byte_if.source   frame_o
);

  back_state_e state_q, state_d;
  job_t        job_q;
  idx_t        idx_q;
  logic [15:0] crc_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_eof_q;

  logic        adv;
  logic        load;
  logic [7:0]  byte_d;
  logic        eof_d;
  idx_t        n_data;
  logic        crc_tail;
  logic [7:0]  data_byte;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign frame_o.valid        = out_valid_q;
  assign frame_o.frame_byte   = out_byte_q;
  assign frame_o.end_of_frame = out_eof_q;

  // The output register can take a new byte when it is empty or being drained.
  assign adv = !out_valid_q || frame_o.ready;

  always_comb begin
    case (job_q.op)
      JOB_READ, JOB_WRITE_SINGLE: n_data = 4'd6;
      JOB_MULTI_HEAD:             n_data = 4'd9;
      default:                    n_data = 4'd2;
    endcase
    crc_tail = (job_q.op == JOB_READ) || (job_q.op == JOB_WRITE_SINGLE) || job_q.last;
  end

  always_comb begin
    data_byte = 8'h00;
    case (job_q.op)
      JOB_READ, JOB_WRITE_SINGLE: begin
        case (idx_q)
          4'd0:    data_byte = job_q.slave_address;
          4'd1:    data_byte = (job_q.op == JOB_READ) ? FN_READ_HOLDING : FN_WRITE_SINGLE;
          4'd2:    data_byte = job_q.register_address[15:8];
          4'd3:    data_byte = job_q.register_address[7:0];
          4'd4:    data_byte = (job_q.op == JOB_READ) ? 8'h00 : job_q.data_word[15:8];
          4'd5:    data_byte = (job_q.op == JOB_READ) ? job_q.register_count
                                                      : job_q.data_word[7:0];
          default: data_byte = 8'h00;
        endcase
      end
      JOB_MULTI_HEAD: begin
        case (idx_q)
          4'd0:    data_byte = job_q.slave_address;
          4'd1:    data_byte = FN_WRITE_MULTI;
          4'd2:    data_byte = job_q.register_address[15:8];
          4'd3:    data_byte = job_q.register_address[7:0];
          4'd4:    data_byte = 8'h00;
          4'd5:    data_byte = job_q.register_count;
          4'd6:    data_byte = {job_q.register_count[6:0], 1'b0};
          4'd7:    data_byte = job_q.data_word[15:8];
          4'd8:    data_byte = job_q.data_word[7:0];
          default: data_byte = 8'h00;
        endcase
      end
      default: begin
        data_byte = (idx_q == 4'd0) ? job_q.data_word[15:8] : job_q.data_word[7:0];
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!status_i.empty) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (adv && (idx_q == n_data - 4'd1)) begin
          state_d = crc_tail ? ST_CRC_LO : ST_IDLE;
        end
      end
      ST_CRC_LO: begin
        if (adv) begin
          state_d = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (adv) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    load   = 1'b0;
    byte_d = data_byte;
    eof_d  = 1'b0;
    case (state_q)
      ST_IDLE: pop_o = !status_i.empty;
      ST_DATA: load = adv;
      ST_CRC_LO: begin
        load   = adv;
        byte_d = crc_q[7:0];
      end
      ST_CRC_HI: begin
        load   = adv;
        byte_d = crc_q[15:8];
        eof_d  = 1'b1;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        idx_q <= '0;
      end else if (state_q == ST_DATA && adv) begin
        idx_q <= idx_q + 4'd1;
      end
      // A frame restarts the checksum unless the job continues an open frame.
      if (pop_o && job_i.op != JOB_MULTI_DATA) begin
        crc_q <= CRC_INIT;
      end else if (state_q == ST_DATA && adv) begin
        crc_q <= crc_byte(crc_q, data_byte);
      end else if (state_q == ST_CRC_HI && adv) begin
        crc_q <= CRC_INIT;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (load) begin
      out_byte_q <= byte_d;
      out_eof_q  <= eof_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> (idx_q < n_data))
    else $error("byte index past end of job");

  a_crc_only_when_closing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC_LO) |-> crc_tail)
    else $error("checksum sent for a job that does not close its frame");

  a_eof_after_crc_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC_HI && adv) |=> (out_valid_q && out_eof_q))
    else $error("final checksum byte not flagged as end of frame");
`endif

endmodule

>>> hw/rtl/modbus_rtu_request_framer.sv
// A command word reaches the output via the job queue, job register and output register.
// Throughput: one frame byte per cycle while the sink is ready, except while the CRC
// sequencer is idle between items, taking the next job from the queue.
// A small job queue lets commands be accepted while the sequencer is still busy.
// Reset is asynchronous and active low: no frame open, CRC at 0xFFFF, queue and output empty.
module modbus_rtu_request_framer import mrf_pkg::*; #(
  parameter int unsigned FifoDepth = MRF_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrf_cmd_if.sink    cmd_i,
  mrf_byte_if.source frame_o
);

  logic         push;
  logic         pop;
  job_t         job_push;
  job_t         job_pop;
  fifo_status_t status;

  mrf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .status_i (status),
    .push_o   (push),
    .job_o    (job_push)
  );

  mrf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job_push),
    .pop_i    (pop),
    .job_o    (job_pop),
    .status_o (status)
  );

  mrf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .job_i    (job_pop),
    .pop_o    (pop),
    .frame_o  (frame_o)
  );

endmodule

>>> tb/modbus_rtu_request_framer_checker.sv
module modbus_rtu_request_framer_checker import mrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrf_cmd_if          cmd_i,
  mrf_byte_if         frame_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_byte_t;

  frame_byte_t expected_bytes_q[$];
  logic [15:0] frame_crc_q;
  logic        multi_open_q;

  initial begin
    mismatch_count_o = 0;
    pending_o = 0;
  end

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data_byte);
    logic [15:0] c;
    c = crc ^ {8'h00, data_byte};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < 64) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
    mismatch_count_o++;
  endtask

  task automatic push_frame_byte(input logic [7:0] data_byte);
    frame_crc_q = crc_update(frame_crc_q, data_byte);
    expected_bytes_q.push_back('{frame_byte: data_byte, end_of_frame: 1'b0});
  endtask

  // The CRC goes out low byte first, and the high byte closes the frame.
  task automatic push_frame_crc();
    expected_bytes_q.push_back('{frame_byte: frame_crc_q[7:0], end_of_frame: 1'b0});
    expected_bytes_q.push_back('{frame_byte: frame_crc_q[15:8], end_of_frame: 1'b1});
    frame_crc_q = CRC_INIT;
  endtask

  task automatic predict_frame_bytes(input logic [1:0] command, input logic [7:0] slave,
                                     input logic [15:0] reg_addr, input logic [7:0] count,
                                     input logic [15:0] data, input logic last_word);
    case (command)
      CMD_READ, CMD_WRITE_SINGLE: begin
        // A single-word request drops any open write multiple frame.
        multi_open_q = 1'b0;
        frame_crc_q = CRC_INIT;
        push_frame_byte(slave);
        push_frame_byte(command == CMD_READ ? FN_READ_HOLDING : FN_WRITE_SINGLE);
        push_frame_byte(reg_addr[15:8]);
        push_frame_byte(reg_addr[7:0]);
        if (command == CMD_READ) begin
          push_frame_byte(8'h00);
          push_frame_byte(count);
        end else begin
          push_frame_byte(data[15:8]);
          push_frame_byte(data[7:0]);
        end
        push_frame_crc();
      end
      CMD_WRITE_MULTI: begin
        if (!multi_open_q) begin
          frame_crc_q = CRC_INIT;
          push_frame_byte(slave);
          push_frame_byte(FN_WRITE_MULTI);
          push_frame_byte(reg_addr[15:8]);
          push_frame_byte(reg_addr[7:0]);
          push_frame_byte(8'h00);
          push_frame_byte(count);
          push_frame_byte({count[6:0], 1'b0});
          multi_open_q = 1'b1;
        end
        push_frame_byte(data[15:8]);
        push_frame_byte(data[7:0]);
        if (last_word) begin
          push_frame_crc();
          multi_open_q = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_frame_byte(input logic [7:0] got_byte, input logic got_eof);
    frame_byte_t want;
    if (expected_bytes_q.size() == 0) begin
      report_mismatch($sformatf("frame byte %02h arrived with none pending", got_byte));
    end else begin
      want = expected_bytes_q.pop_front();
      if (got_byte !== want.frame_byte) begin
        report_mismatch($sformatf("frame_byte %02h, predicted %02h", got_byte,
                                  want.frame_byte));
      end
      if (got_eof !== want.end_of_frame) begin
        report_mismatch($sformatf("end_of_frame %0b on byte %02h, predicted %0b", got_eof,
                                  got_byte, want.end_of_frame));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes_q.delete();
      frame_crc_q = CRC_INIT;
      multi_open_q = 1'b0;
      pending_o = 0;
    end else begin
      if (frame_i.valid && frame_i.ready) begin
        check_frame_byte(frame_i.frame_byte, frame_i.end_of_frame);
      end
      if (cmd_i.valid && cmd_i.ready) begin
        predict_frame_bytes(cmd_i.command, cmd_i.slave_address, cmd_i.register_address,
                            cmd_i.register_count, cmd_i.data_word, cmd_i.last_word);
      end
      pending_o = expected_bytes_q.size();
    end
  end

endmodule

>>> tb/modbus_rtu_request_framer_tb.sv
module modbus_rtu_request_framer_tb import mrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth command code has no meaning and must be dropped by the block.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 340;

  typedef struct {
    logic [1:0]  command;
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [7:0]  register_count;
    logic [15:0] data_word;
    logic        last_word;
  } cmd_word_t;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG_STALL
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_total;
  int unsigned bytes_pending;
  int unsigned burst_left;
  int unsigned words_sent;
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_hold_left;

  mrf_cmd_if  cmd_if ();
  mrf_byte_if frame_if ();

  modbus_rtu_request_framer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .frame_o (frame_if)
  );

  modbus_rtu_request_framer_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_if),
    .frame_i          (frame_if),
    .mismatch_count_o (mismatch_total),
    .pending_o        (bytes_pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // The byte sink switches at random between several stall styles.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 64);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN: frame_if.ready = 1'b1;
      RX_COIN: frame_if.ready = 1'($urandom_range(0, 1));
      RX_PERIODIC: frame_if.ready = (rx_mode_left % 5) != 0;
      default: begin
        if (rx_hold_left > 0) begin
          rx_hold_left--;
          frame_if.ready = 1'b0;
        end else begin
          frame_if.ready = 1'b1;
          rx_hold_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  function automatic cmd_word_t make_word(logic [1:0] command, logic [7:0] slave,
                                          logic [15:0] reg_addr, logic [7:0] count,
                                          logic [15:0] data, logic last_word);
    cmd_word_t w;
    w.command = command;
    w.slave_address = slave;
    w.register_address = reg_addr;
    w.register_count = count;
    w.data_word = data;
    w.last_word = last_word;
    return w;
  endfunction

  function automatic cmd_word_t random_word(logic [1:0] command, logic last_word);
    return make_word(command, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), last_word);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input cmd_word_t w);
    if (burst_left == 0) begin
      cmd_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    cmd_if.command = w.command;
    cmd_if.slave_address = w.slave_address;
    cmd_if.register_address = w.register_address;
    cmd_if.register_count = w.register_count;
    cmd_if.data_word = w.data_word;
    cmd_if.last_word = w.last_word;
    cmd_if.valid = 1'b1;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
    if (w.command != CMD_UNUSED) begin
      words_sent++;
    end
  endtask

  task automatic wait_drained();
    cmd_if.valid = 1'b0;
    while (bytes_pending != 0) @(negedge clk_i);
  endtask

  task automatic send_single_random();
    send_word(random_word($urandom_range(0, 1) ? CMD_WRITE_SINGLE : CMD_READ,
                          1'($urandom_range(0, 1))));
  endtask

  // A write multiple frame with random content; now and then the count disagrees,
  // an unused code slips in, or a single request cuts the frame short.
  task automatic send_multi_frame();
    int unsigned n_words;
    logic        cut_short;
    cmd_word_t   w;
    n_words = $urandom_range(1, 8);
    cut_short = (n_words > 1) && ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n_words; i++) begin
      if (cut_short && i == n_words - 1) begin
        send_single_random();
      end else begin
        w = random_word(CMD_WRITE_MULTI, i == n_words - 1);
        if (i == 0 && $urandom_range(0, 4) != 0) begin
          w.register_count = 8'(n_words);
        end
        send_word(w);
        if (i != n_words - 1 && $urandom_range(0, 19) == 0) begin
          send_word(random_word(CMD_UNUSED, 1'($urandom_range(0, 1))));
        end
      end
    end
  endtask

  task automatic run_directed();
    send_word(make_word(CMD_READ, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(make_word(CMD_READ, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
    send_word(make_word(CMD_WRITE_SINGLE, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(make_word(CMD_WRITE_SINGLE, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
    // Count of 0x80 makes the byte count wrap to zero.
    send_word(make_word(CMD_WRITE_MULTI, 8'hFF, 16'hFFFF, 8'h80, 16'hFFFF, 1'b0));
    send_word(make_word(CMD_UNUSED, 8'h5A, 16'h1234, 8'h03, 16'h4321, 1'b1));
    send_word(make_word(CMD_WRITE_MULTI, 8'h12, 16'h3456, 8'h78, 16'h0000, 1'b0));
    send_word(make_word(CMD_WRITE_MULTI, 8'h00, 16'h0000, 8'h00, 16'hA5A5, 1'b1));
    // Header, one word and CRC from a single item.
    send_word(make_word(CMD_WRITE_MULTI, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b1));
    // A read and then a write single abandon open multi frames.
    send_word(make_word(CMD_WRITE_MULTI, 8'h11, 16'h1234, 8'hFF, 16'h1111, 1'b0));
    send_word(make_word(CMD_READ, 8'h22, 16'h00FF, 8'h10, 16'h2222, 1'b0));
    send_word(make_word(CMD_WRITE_MULTI, 8'h33, 16'hFF00, 8'h02, 16'h3333, 1'b0));
    send_word(make_word(CMD_WRITE_SINGLE, 8'h44, 16'h8001, 8'h01, 16'h4444, 1'b0));
    // Four words sent against a count of one.
    send_word(make_word(CMD_WRITE_MULTI, 8'h01, 16'h0100, 8'h01, 16'hDEAD, 1'b0));
    send_word(make_word(CMD_WRITE_MULTI, 8'h02, 16'h0200, 8'h09, 16'hBEEF, 1'b0));
    send_word(make_word(CMD_WRITE_MULTI, 8'h03, 16'h0300, 8'h09, 16'h0F0F, 1'b0));
    send_word(make_word(CMD_WRITE_MULTI, 8'h04, 16'h0400, 8'h09, 16'hF0F0, 1'b1));
    send_word(make_word(CMD_UNUSED, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(make_word(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
    send_word(make_word(CMD_WRITE_MULTI, 8'h7F, 16'h7FFF, 8'h7F, 16'h8000, 1'b1));
  endtask

  initial begin
    #2_000_000;
    $display("FAIL modbus_rtu_request_framer");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic        drained_once;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_READ;
    cmd_if.slave_address = '0;
    cmd_if.register_address = '0;
    cmd_if.register_count = '0;
    cmd_if.data_word = '0;
    cmd_if.last_word = 1'b0;
    frame_if.ready = 1'b0;
    rx_mode = RX_OPEN;
    rx_mode_left = 0;
    rx_hold_left = 0;
    burst_left = 0;
    words_sent = 0;
    drained_once = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    wait_drained();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_multi_frame();
      end else if (pick < 80) begin
        send_single_random();
      end else if (pick < 88) begin
        send_word(random_word(CMD_UNUSED, 1'($urandom_range(0, 1))));
      end else begin
        send_word(random_word(CMD_WRITE_MULTI, 1'($urandom_range(0, 1))));
      end
      if (!drained_once && words_sent > RANDOM_WORDS / 2) begin
        drained_once = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (16) @(negedge clk_i);
    if (mismatch_total == 0) begin
      $display("PASS modbus_rtu_request_framer");
    end else begin
      $display("FAIL modbus_rtu_request_framer");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mrf_pkg.sv
hw/rtl/mrf_cmd_if.sv
hw/rtl/mrf_byte_if.sv
hw/rtl/mrf_front.sv
hw/rtl/mrf_fifo.sv
hw/rtl/mrf_back.sv
hw/rtl/modbus_rtu_request_framer.sv
tb/modbus_rtu_request_framer_checker.sv
tb/modbus_rtu_request_framer_tb.sv
